// ----- rtl/itp_pkg.sv -----
package itp_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } itp_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_expr;
    logic [1:0] status;
  } itp_out_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  // operator priority, 0 for everything else including '('
  function automatic logic [2:0] prio_of(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    unique case (c)
      CH_PLUS:  p = 3'd1;
      CH_MINUS: p = 3'd2;
      CH_MUL:   p = 3'd3;
      CH_DIV:   p = 3'd4;
      CH_POW:   p = 3'd5;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/itp_stack_mem.sv -----
module itp_stack_mem #(
  parameter int STACK_DEPTH = 32,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] mem_q;
  logic [7:0] wr_data_q;
  logic       bypass;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q     <= mem[rd_addr];
    wr_data_q <= wr_data;
    bypass    <= wr_en && (wr_addr == rd_addr);
  end

  // a read of the entry written at the same edge returns the new data
  assign rd_data = bypass ? wr_data_q : mem_q;

endmodule

// ----- rtl/itp_ctrl.sv -----
module itp_ctrl #(
  parameter int STACK_DEPTH = 32,
  parameter int AW          = $clog2(STACK_DEPTH),
  parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  itp_pkg::itp_in_t item,
  output logic             result_valid,
  input  logic             result_stall,
  output itp_pkg::itp_out_t result,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data
);
  import itp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0] err, err_next;
  logic [7:0] ch, ch_next;
  logic       last, last_next;
  itp_out_t   hold, hold_next;
  logic       hold_full, hold_full_next;
  itp_out_t   result_next;
  logic       result_valid_next;

  logic       has_top;
  logic       out_free;
  logic       can_emit;
  logic       do_emit;
  logic [7:0] emit_char;
  logic       do_push;
  logic [2:0] p_in;
  logic [2:0] p_top;
  state_t     after_eval;

  assign has_top    = (count != '0);
  assign out_free   = !result_valid || !result_stall;
  assign can_emit   = !hold_full || out_free;
  assign p_in       = prio_of(ch);
  assign p_top      = prio_of(rd_data);
  assign after_eval = last ? S_FLUSH : S_DONE;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    count_next        = count;
    err_next          = err;
    ch_next           = ch;
    last_next         = last;
    hold_next         = hold;
    hold_full_next    = hold_full;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    do_emit           = 1'b0;
    emit_char         = rd_data;
    do_push           = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = count[AW-1:0];
    wr_data           = ch;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ch_next    = item.in_char;
          last_next  = item.is_last;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (ch == CH_OPEN) begin
          do_push    = 1'b1;
          state_next = after_eval;
        end else if (ch == CH_CLOSE) begin
          priority if (has_top && rd_data != CH_OPEN) begin
            if (can_emit) begin
              do_emit    = 1'b1;
              count_next = count - CW'(1);
            end
          end else if (has_top) begin
            count_next = count - CW'(1);
            state_next = after_eval;
          end else begin
            if (err == ST_OK) begin
              err_next = ST_UNMATCHED;
            end
            state_next = after_eval;
          end
        end else if (p_in != 3'd0) begin
          if (has_top && p_top >= p_in) begin
            if (can_emit) begin
              do_emit    = 1'b1;
              count_next = count - CW'(1);
            end
          end else begin
            do_push    = 1'b1;
            state_next = after_eval;
          end
        end else begin
          if (can_emit) begin
            do_emit    = 1'b1;
            emit_char  = ch;
            state_next = after_eval;
          end
        end
      end
      S_FLUSH: begin
        if (has_top) begin
          if (can_emit) begin
            do_emit    = 1'b1;
            count_next = count - CW'(1);
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (hold_full) begin
          if (out_free) begin
            result_next             = hold;
            result_next.end_of_expr = last;
            result_valid_next       = 1'b1;
            hold_full_next          = 1'b0;
            if (last) begin
              err_next = ST_OK;
            end
            state_next = S_IDLE;
          end
        end else if (last) begin
          if (out_free) begin
            result_next       = '{out_char: 8'd0, char_valid: 1'b0,
                                  end_of_expr: 1'b1, status: err};
            result_valid_next = 1'b1;
            err_next          = ST_OK;
            state_next        = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_push) begin
      if (count == CW'(STACK_DEPTH)) begin
        if (err == ST_OK) begin
          err_next = ST_OVERFLOW;
        end
      end else begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
      end
    end

    // one-deep hold so the last item of an expression can be tagged
    if (do_emit) begin
      if (hold_full) begin
        result_next       = hold;
        result_valid_next = 1'b1;
      end
      hold_next      = '{out_char: emit_char, char_valid: 1'b1,
                         end_of_expr: 1'b0, status: err};
      hold_full_next = 1'b1;
    end
  end

  // address the new top of stack so its data is ready next cycle
  always_comb begin
    if (count_next == '0) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(count_next - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      hold_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      err          <= err_next;
      hold_full    <= hold_full_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ch     <= ch_next;
    last   <= last_next;
    hold   <= hold_next;
    result <= result_next;
  end

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// Shunting-yard infix-to-postfix converter. One expression character is taken per
// transaction; the character flagged is_last closes the expression and flushes the
// operator stack. Each character is accepted, evaluated against the stack top,
// popping stacked operators one at a time, and handed to the output register; the
// last character also flushes the remaining stack entries before its hand-off. No
// new character is taken before the previous one is done. Results leave through an
// output register, and the block waits for it to drain when result_stall holds.
// The final result of an expression carries end_of_expr; an expression whose last
// character and flush produce nothing gets a bare end result with char_valid low.
// status holds the first stack overflow or unmatched ')' so far in the expression.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  itp_pkg::itp_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output itp_pkg::itp_out_t result
);
  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  itp_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.char_valid |-> result.end_of_expr && result.out_char == 8'd0)
    else $error("bare result without end marker");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status == ST_OK || result.status == ST_OVERFLOW
                     || result.status == ST_UNMATCHED)
    else $error("bad status code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input taken while evaluating");
`endif

endmodule
